// ----- design/jcb_pkg.sv -----
// shared types for the jacobi symbol block: controller states, command and status groups
package jcb_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REDUCE,
      ST_FIX,
      ST_LOOP,
      ST_MOD,
      ST_FINISH
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;      // take a new item from the request channel
      logic mod_step;  // one restoring remainder step
      logic fix_neg;   // turn a negative residue non-negative
      logic halve;     // strip one factor of two
      logic swap;      // reciprocity swap and start of a new remainder
      logic capture;   // write the result register
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic n_bad;     // modulus zero or even
      logic mod_last;  // final remainder step
      logic a_zero;
      logic a_even;
   } status_type;

endpackage

// ----- design/jcb_if.sv -----
// request and response channel interfaces of the jacobi symbol block
interface jcb_req_if #(parameter int WIDTH = 32);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] value;
   logic        [WIDTH-2:0] modulus;

   modport source (output valid, output value, output modulus, input ready);
   modport sink (input valid, input value, input modulus, output ready);
endinterface

interface jcb_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [1:0] symbol;
   logic              valid_res;

   modport source (output valid, output symbol, output valid_res, input ready);
   modport sink (input valid, input symbol, input valid_res, output ready);
endinterface

// ----- design/jcb_ctrl.sv -----
// controller state machine of the jacobi symbol block
module jcb_ctrl
   import jcb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      full_ff, full_in;
   logic      slot_free;

   assign slot_free = !full_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         full_ff  <= full_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.n_bad ? ST_FINISH : ST_REDUCE;
         end
         ST_REDUCE: begin
            if (status.mod_last) state_in = ST_FIX;
         end
         ST_FIX: state_in = ST_LOOP;
         ST_LOOP: begin
            if (status.a_zero) state_in = ST_FINISH;
            else if (!status.a_even) state_in = ST_MOD;
         end
         ST_MOD: begin
            if (status.mod_last) state_in = ST_LOOP;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CHECK: ;
         ST_REDUCE: cmd.mod_step = 1'b1;
         ST_FIX: cmd.fix_neg = 1'b1;
         ST_LOOP: begin
            cmd.halve = !status.a_zero && status.a_even;
            cmd.swap  = !status.a_zero && !status.a_even;
         end
         ST_MOD: cmd.mod_step = 1'b1;
         ST_FINISH: cmd.capture = slot_free;
         default: ;
      endcase
   end

   assign rsp_valid = full_ff;

   always_comb begin
      full_in = full_ff;
      if (rsp_ready) full_in = 1'b0;
      if (cmd.capture) full_in = 1'b1;
   end

endmodule

// ----- design/jcb_dpath.sv -----
// datapath of the jacobi symbol block: operand registers, remainder unit, result register
module jcb_dpath
   import jcb_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                    clock,
   input  cmd_type                 cmd,
   input  logic signed [WIDTH-1:0] value,
   input  logic        [WIDTH-2:0] modulus,
   output status_type              status,
   output logic signed [1:0]       symbol,
   output logic                    valid_res
);

   localparam int M  = WIDTH - 1;
   localparam int CW = $clog2(WIDTH);

   logic [M-1:0]     a_ff, a_in;
   logic [M-1:0]     n_ff, n_in;
   logic [M-1:0]     rem_ff, rem_in;
   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             sgn_ff, sgn_in;
   logic [1:0]       sym_ff, sym_in;
   logic             vres_ff, vres_in;

   logic [WIDTH-1:0] trial;
   logic [WIDTH-1:0] diff;
   logic [M-1:0]     step_rem;
   logic [WIDTH-1:0] mag;

   // magnitude of the signed value, the most negative one maps to 2^(WIDTH-1)
   assign mag = value[WIDTH-1] ? (WIDTH'(0) - value) : value;

   // one restoring remainder step
   assign trial    = {rem_ff, dvd_ff[WIDTH-1]};
   assign diff     = trial - {1'b0, n_ff};
   assign step_rem = (trial >= {1'b0, n_ff}) ? diff[M-1:0] : trial[M-1:0];

   assign status.n_bad    = !n_ff[0];
   assign status.mod_last = (cnt_ff == '0);
   assign status.a_zero   = (a_ff == '0);
   assign status.a_even   = !a_ff[0];

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      sgn_ff  <= sgn_in;
      sym_ff  <= sym_in;
      vres_ff <= vres_in;
   end

   always_comb begin
      a_in    = a_ff;
      n_in    = n_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      sgn_in  = sgn_ff;
      sym_in  = sym_ff;
      vres_in = vres_ff;
      if (cmd.load) begin
         n_in   = modulus;
         dvd_in = mag;
         neg_in = value[WIDTH-1];
         rem_in = '0;
         cnt_in = CW'(WIDTH - 1);
         sgn_in = 1'b0;
         a_in   = '0;
      end
      if (cmd.mod_step) begin
         rem_in = step_rem;
         dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) a_in = step_rem;
      end
      if (cmd.fix_neg) begin
         if (neg_ff && a_ff != '0) a_in = n_ff - a_ff;
      end
      if (cmd.halve) begin
         a_in = {1'b0, a_ff[M-1:1]};
         if (n_ff[2:0] == 3'd3 || n_ff[2:0] == 3'd5) sgn_in = !sgn_ff;
      end
      if (cmd.swap) begin
         // old modulus becomes the dividend, the odd value the new modulus
         n_in   = a_ff;
         dvd_in = {1'b0, n_ff};
         rem_in = '0;
         cnt_in = CW'(WIDTH - 1);
         if (a_ff[1:0] == 2'd3 && n_ff[1:0] == 2'd3) sgn_in = !sgn_ff;
      end
      if (cmd.capture) begin
         vres_in = n_ff[0];
         if (n_ff == M'(1)) sym_in = sgn_ff ? 2'b11 : 2'b01;
         else sym_in = 2'b00;
      end
   end

   assign symbol    = sym_ff;
   assign valid_res = vres_ff;

endmodule

// ----- design/jacobi_symbol.sv -----
// jacobi symbol unit: top level joining controller, datapath and the two channels
//
// takes a signed value and a modulus and returns the jacobi symbol (-1, 0 or 1)
// with a flag that is set when the modulus is odd and non-zero; an even or zero
// modulus gives symbol 0 with the flag clear. one item is worked at a time. the
// value is first reduced by a bit-serial restoring remainder unit, then the
// binary loop runs, stripping factors of two and doing reciprocity swaps, the
// swap reusing the same remainder unit. the result sits in an output register,
// so a new item is taken while it waits; the next result is held in the finish
// step until the waiting one has been read.
module jacobi_symbol
   import jcb_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   jcb_req_if.sink   req_ch,
   jcb_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   // sequencing of reduce, halve, swap and result steps
   jcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // operands, sign accumulator, remainder unit and result register
   jcb_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock     (clock),
      .cmd       (cmd),
      .value     (req_ch.value),
      .modulus   (req_ch.modulus),
      .status    (status),
      .symbol    (rsp_ch.symbol),
      .valid_res (rsp_ch.valid_res)
   );

endmodule
